FILE: hw/rtl/rrsp_pkg.sv
// Shared types, constants and helpers for the request stream parser.
`timescale 1ns / 1ps

package rrsp_pkg;

  // Widest decimal number accepted in a count or length header.
  localparam int COUNT_BITS = 32;
  localparam int ACC_W      = COUNT_BITS + 4;

  // Framing characters.
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Parser phase, one-hot.
  typedef enum logic [11:0] {
    PH_STAR      = 12'b0000_0000_0001,
    PH_CNT_FIRST = 12'b0000_0000_0010,
    PH_CNT_DIG   = 12'b0000_0000_0100,
    PH_CNT_LF    = 12'b0000_0000_1000,
    PH_DOLLAR    = 12'b0000_0001_0000,
    PH_LEN_FIRST = 12'b0000_0010_0000,
    PH_LEN_DIG   = 12'b0000_0100_0000,
    PH_LEN_LF    = 12'b0000_1000_0000,
    PH_PAYLOAD   = 12'b0001_0000_0000,
    PH_TRAIL_CR  = 12'b0010_0000_0000,
    PH_TRAIL_LF  = 12'b0100_0000_0000,
    PH_ERROR     = 12'b1000_0000_0000
  } phase_t;

  // Sticky error codes.
  typedef enum logic [2:0] {
    ERR_NONE   = 3'd0,
    ERR_PREFIX = 3'd1,
    ERR_NUMBER = 3'd2,
    ERR_CRLF   = 3'd3,
    ERR_ZERO   = 3'd4
  } err_t;

  // Architectural parser state.
  typedef struct packed {
    phase_t                  phase;
    logic [COUNT_BITS-1:0]   accum;
    logic [COUNT_BITS-1:0]   args_left;
    logic [COUNT_BITS-1:0]   cur_arg;
    logic [COUNT_BITS-1:0]   payload_left;
    err_t                    err;
  } state_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  byte_out;
    logic        is_payload;
    logic [31:0] arg_index;
    logic        command_begin;
    logic [31:0] arg_count;
    logic        arg_begin;
    logic [31:0] arg_length;
    logic        arg_end;
    logic        command_done;
    logic        error_flag;
    err_t        error_code;
  } result_t;

  // Low 32 bits of a header-width value, zero-extended when narrower.
  function automatic logic [31:0] low32(logic [COUNT_BITS-1:0] v);
    logic [COUNT_BITS+31:0] w;
    w = {32'b0, v};
    return w[31:0];
  endfunction

endpackage

FILE: hw/rtl/rrsp_if.sv
// Valid/ready stream interfaces for the parser's input bytes and results.
`timescale 1ns / 1ps

interface rrsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface rrsp_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic        is_payload;
  logic [31:0] arg_index;
  logic        command_begin;
  logic [31:0] arg_count;
  logic        arg_begin;
  logic [31:0] arg_length;
  logic        arg_end;
  logic        command_done;
  logic        error_flag;
  logic [2:0]  error_code;

  modport source (
    output valid, output byte_out, output is_payload, output arg_index,
    output command_begin, output arg_count, output arg_begin, output arg_length,
    output arg_end, output command_done, output error_flag, output error_code,
    input ready
  );
  modport sink (
    input valid, input byte_out, input is_payload, input arg_index,
    input command_begin, input arg_count, input arg_begin, input arg_length,
    input arg_end, input command_done, input error_flag, input error_code,
    output ready
  );
endinterface

FILE: hw/rtl/rrsp_step.sv
// Combinational next-state and result logic for one request byte.
`timescale 1ns / 1ps

module rrsp_step (
  input  rrsp_pkg::state_t  cur,
  input  logic [7:0]        byte_in,
  output rrsp_pkg::state_t  nxt,
  output rrsp_pkg::result_t res
);

  logic                           digit;
  logic [3:0]                     dval;
  logic [rrsp_pkg::ACC_W-1:0]     ext;
  logic [rrsp_pkg::ACC_W-1:0]     prod;
  logic                           ovf;
  logic [rrsp_pkg::COUNT_BITS-1:0] acc_new;

  // Decimal accumulate: accum * 10 + digit, built from two shifts.
  always_comb begin
    digit   = (byte_in >= rrsp_pkg::CH_ZERO) && (byte_in <= rrsp_pkg::CH_NINE);
    dval    = 4'(byte_in - rrsp_pkg::CH_ZERO);
    ext     = {4'b0, cur.accum};
    prod    = (ext << 3) + (ext << 1) + rrsp_pkg::ACC_W'(dval);
    ovf     = |prod[rrsp_pkg::ACC_W-1:rrsp_pkg::COUNT_BITS];
    acc_new = prod[rrsp_pkg::COUNT_BITS-1:0];
  end

  // Phase transitions and per-byte markers.
  always_comb begin
    nxt = cur;
    res = '0;
    res.byte_out  = byte_in;
    res.arg_index = rrsp_pkg::low32(cur.cur_arg);

    unique case (cur.phase) inside
      rrsp_pkg::PH_STAR: begin
        if (byte_in == rrsp_pkg::CH_STAR) begin
          nxt.accum = '0;
          nxt.phase = rrsp_pkg::PH_CNT_FIRST;
        end else begin
          nxt.err   = rrsp_pkg::ERR_PREFIX;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end
      end
      rrsp_pkg::PH_DOLLAR: begin
        if (byte_in == rrsp_pkg::CH_DOLLAR) begin
          nxt.accum = '0;
          nxt.phase = rrsp_pkg::PH_LEN_FIRST;
        end else begin
          nxt.err   = rrsp_pkg::ERR_PREFIX;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end
      end
      rrsp_pkg::PH_CNT_FIRST, rrsp_pkg::PH_LEN_FIRST: begin
        if (!digit || ovf) begin
          nxt.err   = rrsp_pkg::ERR_NUMBER;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end else begin
          nxt.accum = acc_new;
          nxt.phase = (cur.phase == rrsp_pkg::PH_CNT_FIRST) ?
                      rrsp_pkg::PH_CNT_DIG : rrsp_pkg::PH_LEN_DIG;
        end
      end
      rrsp_pkg::PH_CNT_DIG, rrsp_pkg::PH_LEN_DIG: begin
        if (digit) begin
          if (ovf) begin
            nxt.err   = rrsp_pkg::ERR_NUMBER;
            nxt.phase = rrsp_pkg::PH_ERROR;
          end else begin
            nxt.accum = acc_new;
          end
        end else if (byte_in == rrsp_pkg::CH_CR) begin
          nxt.phase = (cur.phase == rrsp_pkg::PH_CNT_DIG) ?
                      rrsp_pkg::PH_CNT_LF : rrsp_pkg::PH_LEN_LF;
        end else begin
          nxt.err   = rrsp_pkg::ERR_CRLF;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end
      end
      rrsp_pkg::PH_CNT_LF: begin
        if (byte_in != rrsp_pkg::CH_LF) begin
          nxt.err   = rrsp_pkg::ERR_CRLF;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end else if (cur.accum == '0) begin
          nxt.err   = rrsp_pkg::ERR_ZERO;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end else begin
          res.command_begin = 1'b1;
          res.arg_count     = rrsp_pkg::low32(cur.accum);
          nxt.args_left     = cur.accum;
          nxt.cur_arg       = '0;
          nxt.phase         = rrsp_pkg::PH_DOLLAR;
        end
      end
      rrsp_pkg::PH_LEN_LF: begin
        if (byte_in != rrsp_pkg::CH_LF) begin
          nxt.err   = rrsp_pkg::ERR_CRLF;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end else begin
          res.arg_begin    = 1'b1;
          res.arg_length   = rrsp_pkg::low32(cur.accum);
          nxt.payload_left = cur.accum;
          nxt.phase        = (cur.accum != '0) ?
                             rrsp_pkg::PH_PAYLOAD : rrsp_pkg::PH_TRAIL_CR;
        end
      end
      rrsp_pkg::PH_PAYLOAD: begin
        res.is_payload   = 1'b1;
        nxt.payload_left = cur.payload_left - 1'b1;
        if (cur.payload_left == rrsp_pkg::COUNT_BITS'(1)) begin
          nxt.phase = rrsp_pkg::PH_TRAIL_CR;
        end
      end
      rrsp_pkg::PH_TRAIL_CR: begin
        if (byte_in == rrsp_pkg::CH_CR) begin
          nxt.phase = rrsp_pkg::PH_TRAIL_LF;
        end else begin
          nxt.err   = rrsp_pkg::ERR_CRLF;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end
      end
      rrsp_pkg::PH_TRAIL_LF: begin
        if (byte_in != rrsp_pkg::CH_LF) begin
          nxt.err   = rrsp_pkg::ERR_CRLF;
          nxt.phase = rrsp_pkg::PH_ERROR;
        end else begin
          res.arg_end   = 1'b1;
          nxt.args_left = cur.args_left - 1'b1;
          if (cur.args_left == rrsp_pkg::COUNT_BITS'(1)) begin
            res.command_done = 1'b1;
            nxt.cur_arg      = '0;
            nxt.phase        = rrsp_pkg::PH_STAR;
          end else begin
            nxt.cur_arg = cur.cur_arg + 1'b1;
            nxt.phase   = rrsp_pkg::PH_DOLLAR;
          end
        end
      end
      rrsp_pkg::PH_ERROR: begin
        nxt.phase = rrsp_pkg::PH_ERROR;
      end
      default: begin
        nxt.phase = rrsp_pkg::PH_ERROR;
      end
    endcase

    // On and after an error, a byte gives only its echo, the flag and code.
    if (nxt.phase == rrsp_pkg::PH_ERROR) begin
      res.arg_index  = '0;
      res.error_flag = 1'b1;
    end
    res.error_code = nxt.err;
  end

endmodule

FILE: hw/rtl/resp_request_stream_parser_unit.sv
// Top level of the request stream parser: state register, step logic, result register.
`timescale 1ns / 1ps

// Deframes a request stream of '*'-count commands with '$'-length arguments, one byte
// per transfer, and returns one result per byte: the byte echoed, payload marking with
// the argument index, the decoded count and length on the LF closing each header, and
// argument-end and command-done markers. The block accepts one byte every cycle unless
// the result side stalls; the result appears in the cycle after its byte is taken and
// sits in a single result register, so a new byte is taken whenever that register is
// empty or being drained in the same cycle. Header numbers up to 32 bits are decoded.
// The first framing error is latched and reported on every later byte until reset.

module resp_request_stream_parser_unit (
  input  logic       clk,
  input  logic       rst_n,
  rrsp_in_if.sink    in_stream,
  rrsp_out_if.source out_stream
);

  rrsp_pkg::state_t  state_r;
  rrsp_pkg::state_t  state_nxt;
  rrsp_pkg::result_t res_nxt;
  rrsp_pkg::result_t res_r;
  logic              out_valid_r;
  logic              in_xfer;

  // A byte is taken when the result register is free or drains this cycle.
  assign in_stream.ready = !out_valid_r || out_stream.ready;
  assign in_xfer         = in_stream.valid && in_stream.ready;

  rrsp_step u_step (
    .cur     (state_r),
    .byte_in (in_stream.byte_in),
    .nxt     (state_nxt),
    .res     (res_nxt)
  );

  // Parser state advances on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase        <= rrsp_pkg::PH_STAR;
      state_r.accum        <= '0;
      state_r.args_left    <= '0;
      state_r.cur_arg      <= '0;
      state_r.payload_left <= '0;
      state_r.err          <= rrsp_pkg::ERR_NONE;
    end else if (in_xfer) begin
      state_r <= state_nxt;
    end
  end

  // Result register and its valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      res_r <= res_nxt;
    end
  end

  assign out_stream.valid         = out_valid_r;
  assign out_stream.byte_out      = res_r.byte_out;
  assign out_stream.is_payload    = res_r.is_payload;
  assign out_stream.arg_index     = res_r.arg_index;
  assign out_stream.command_begin = res_r.command_begin;
  assign out_stream.arg_count     = res_r.arg_count;
  assign out_stream.arg_begin     = res_r.arg_begin;
  assign out_stream.arg_length    = res_r.arg_length;
  assign out_stream.arg_end       = res_r.arg_end;
  assign out_stream.command_done  = res_r.command_done;
  assign out_stream.error_flag    = res_r.error_flag;
  assign out_stream.error_code    = res_r.error_code;

  // The error state is never left without a reset.
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == rrsp_pkg::PH_ERROR |=> state_r.phase == rrsp_pkg::PH_ERROR)
    else $error("parser left the error state");

  // A command never begins with a zero argument count.
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.command_begin |-> res_r.arg_count != 32'd0)
    else $error("command_begin with zero count");

  // Payload bytes are never flagged as errors.
  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.is_payload |-> !res_r.error_flag)
    else $error("payload byte reported with error");

  // In the payload phase there is always at least one byte left.
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.phase == rrsp_pkg::PH_PAYLOAD |-> state_r.payload_left != '0)
    else $error("payload phase with nothing left");

endmodule

FILE: tb/rrsp_result_checker.sv
// Checker for the request stream parser: tracks the parse state and checks every result transfer.
`timescale 1ns / 1ps

module rrsp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  rrsp_in_if          in_mon,
  rrsp_out_if         out_mon,
  output int unsigned mismatches,
  output int unsigned pending
);

  import rrsp_pkg::*;

  // Parser state as the block should hold it.
  phase_t                ph;
  logic [COUNT_BITS-1:0] accum;
  logic [COUNT_BITS-1:0] args_left;
  logic [COUNT_BITS-1:0] cur_arg;
  logic [COUNT_BITS-1:0] payload_left;
  err_t                  sticky;

  // Results predicted for accepted bytes, oldest first.
  result_t     expected_results[$];
  result_t     got;
  result_t     want;
  string       diffs;
  int unsigned fail_total;

  function automatic logic [31:0] lo32(input logic [COUNT_BITS-1:0] v);
    logic [63:0] wide;
    wide = 64'(v);
    return wide[31:0];
  endfunction

  function automatic void enter_error(input err_t code);
    sticky = code;
    ph     = PH_ERROR;
  endfunction

  // Appends one decimal digit; returns 0 when the header would no longer fit.
  function automatic logic take_digit(input logic [7:0] b);
    logic [COUNT_BITS+3:0] grown;
    grown = {4'b0, accum} * 10 + (b - CH_ZERO);
    if (grown[COUNT_BITS+3:COUNT_BITS] != 0) return 1'b0;
    accum = grown[COUNT_BITS-1:0];
    return 1'b1;
  endfunction

  // Advances the parse state by one byte and returns the result that byte produces.
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t               r;
    logic                  is_digit;
    logic [COUNT_BITS-1:0] idx;
    is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    idx        = cur_arg;
    r          = '0;
    r.byte_out = b;
    case (ph)
      PH_STAR: begin
        if (b == CH_STAR) begin
          accum = '0;
          ph    = PH_CNT_FIRST;
        end else begin
          enter_error(ERR_PREFIX);
        end
      end
      PH_DOLLAR: begin
        if (b == CH_DOLLAR) begin
          accum = '0;
          ph    = PH_LEN_FIRST;
        end else begin
          enter_error(ERR_PREFIX);
        end
      end
      PH_CNT_FIRST, PH_LEN_FIRST: begin
        if (!is_digit || !take_digit(b)) enter_error(ERR_NUMBER);
        else ph = (ph == PH_CNT_FIRST) ? PH_CNT_DIG : PH_LEN_DIG;
      end
      PH_CNT_DIG, PH_LEN_DIG: begin
        if (is_digit) begin
          if (!take_digit(b)) enter_error(ERR_NUMBER);
        end else if (b == CH_CR) begin
          ph = (ph == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
        end else begin
          enter_error(ERR_CRLF);
        end
      end
      PH_CNT_LF: begin
        if (b != CH_LF) begin
          enter_error(ERR_CRLF);
        end else if (accum == 0) begin
          enter_error(ERR_ZERO);
        end else begin
          r.command_begin = 1'b1;
          r.arg_count     = lo32(accum);
          args_left       = accum;
          cur_arg         = '0;
          ph              = PH_DOLLAR;
        end
      end
      PH_LEN_LF: begin
        if (b != CH_LF) begin
          enter_error(ERR_CRLF);
        end else begin
          r.arg_begin  = 1'b1;
          r.arg_length = lo32(accum);
          payload_left = accum;
          ph           = (accum != 0) ? PH_PAYLOAD : PH_TRAIL_CR;
        end
      end
      PH_PAYLOAD: begin
        r.is_payload = 1'b1;
        payload_left = payload_left - 1'b1;
        if (payload_left == 0) ph = PH_TRAIL_CR;
      end
      PH_TRAIL_CR: begin
        if (b == CH_CR) ph = PH_TRAIL_LF;
        else enter_error(ERR_CRLF);
      end
      PH_TRAIL_LF: begin
        if (b != CH_LF) begin
          enter_error(ERR_CRLF);
        end else begin
          r.arg_end = 1'b1;
          args_left = args_left - 1'b1;
          if (args_left == 0) begin
            r.command_done = 1'b1;
            cur_arg        = '0;
            ph             = PH_STAR;
          end else begin
            cur_arg = cur_arg + 1'b1;
            ph      = PH_DOLLAR;
          end
        end
      end
      default: ph = PH_ERROR;
    endcase
    r.arg_index  = (ph == PH_ERROR) ? 32'd0 : lo32(idx);
    r.error_flag = (ph == PH_ERROR);
    r.error_code = sticky;
    return r;
  endfunction

  function automatic string show_result(input result_t r);
    return $sformatf({"byte=%02h pay=%0b idx=%0d cbeg=%0b cnt=%0d abeg=%0b len=%0d ",
                      "aend=%0b done=%0b err=%0b code=%0d"},
                     r.byte_out, r.is_payload, r.arg_index, r.command_begin, r.arg_count,
                     r.arg_begin, r.arg_length, r.arg_end, r.command_done, r.error_flag,
                     r.error_code);
  endfunction

  // Only the first ten failures are printed; all are counted.
  task automatic note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) $display("[%0t] %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      ph           = PH_STAR;
      accum        = '0;
      args_left    = '0;
      cur_arg      = '0;
      payload_left = '0;
      sticky       = ERR_NONE;
      expected_results.delete();
    end else begin
      // A result transfer is checked against the oldest prediction.
      if (out_mon.valid && out_mon.ready) begin
        got.byte_out      = out_mon.byte_out;
        got.is_payload    = out_mon.is_payload;
        got.arg_index     = out_mon.arg_index;
        got.command_begin = out_mon.command_begin;
        got.arg_count     = out_mon.arg_count;
        got.arg_begin     = out_mon.arg_begin;
        got.arg_length    = out_mon.arg_length;
        got.arg_end       = out_mon.arg_end;
        got.command_done  = out_mon.command_done;
        got.error_flag    = out_mon.error_flag;
        got.error_code    = err_t'(out_mon.error_code);
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with nothing outstanding: %s", show_result(got)));
        end else begin
          want  = expected_results.pop_front();
          diffs = "";
          if (got.byte_out !== want.byte_out) diffs = {diffs, " byte_out"};
          if (got.is_payload !== want.is_payload) diffs = {diffs, " is_payload"};
          if (got.arg_index !== want.arg_index) diffs = {diffs, " arg_index"};
          if (got.command_begin !== want.command_begin) diffs = {diffs, " command_begin"};
          if (got.arg_count !== want.arg_count) diffs = {diffs, " arg_count"};
          if (got.arg_begin !== want.arg_begin) diffs = {diffs, " arg_begin"};
          if (got.arg_length !== want.arg_length) diffs = {diffs, " arg_length"};
          if (got.arg_end !== want.arg_end) diffs = {diffs, " arg_end"};
          if (got.command_done !== want.command_done) diffs = {diffs, " command_done"};
          if (got.error_flag !== want.error_flag) diffs = {diffs, " error_flag"};
          if (got.error_code !== want.error_code) diffs = {diffs, " error_code"};
          if (diffs != "") begin
            note_failure($sformatf("mismatch on%s\n  expected %s\n  actual   %s",
                                   diffs, show_result(want), show_result(got)));
          end
        end
      end
      // Every accepted byte yields exactly one result.
      if (in_mon.valid && in_mon.ready) begin
        expected_results.insert(expected_results.size(), parse_byte(in_mon.byte_in));
      end
    end
    mismatches <= fail_total;
    pending    <= expected_results.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the request stream parser: clock, reset, byte stream, result drain and verdict.
`timescale 1ns / 1ps

module tb;

  import rrsp_pkg::*;

  localparam int unsigned RANDOM_BYTES = 400;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned IDLE_LIMIT   = 2000;

  // How the stream ends; the error is sticky, so only one kind fits in a run.
  typedef enum int unsigned {
    TAIL_PREFIX_STAR,
    TAIL_PREFIX_DOLLAR,
    TAIL_EMPTY_NUMBER,
    TAIL_WIDE_NUMBER,
    TAIL_NUMBER_END,
    TAIL_PAYLOAD_END,
    TAIL_ZERO_COUNT,
    TAIL_MAX_HEADERS
  } tail_kind_t;

  logic        clk;
  logic        rst_n;
  int unsigned bytes_sent;
  int unsigned idle_cycles;
  int unsigned mismatches;
  int unsigned pending;
  logic [7:0]  req_bytes[$];

  rrsp_in_if  in_ch ();
  rrsp_out_if out_ch ();

  resp_request_stream_parser_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  rrsp_result_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Mostly short gaps, some long ones; none at all in quiet stretches.
  function automatic int unsigned pick_gap(input logic quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  function automatic int unsigned rand_zeros();
    return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
  endfunction

  function automatic logic [7:0] pick_other(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] pick_non_digit(input logic allow_cr);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= CH_ZERO && b <= CH_NINE) || (!allow_cr && b == CH_CR));
    return b;
  endfunction

  // Appends one byte to the end of the request stream.
  task automatic add_byte(input logic [7:0] b);
    req_bytes.insert(req_bytes.size(), b);
  endtask

  task automatic put_crlf();
    add_byte(CH_CR);
    add_byte(CH_LF);
  endtask

  task automatic put_digits(input logic [63:0] v, input int unsigned zeros);
    string s;
    s = $sformatf("%0d", v);
    repeat (zeros) add_byte(CH_ZERO);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic put_header(input logic [7:0] prefix, input logic [63:0] v,
                            input int unsigned zeros);
    add_byte(prefix);
    put_digits(v, zeros);
    put_crlf();
  endtask

  // Payload content is mostly random, with framing characters mixed in now and then.
  task automatic put_payload(input int unsigned len);
    repeat (len) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: add_byte(CH_CR);
          1: add_byte(CH_LF);
          2: add_byte(CH_STAR);
          default: add_byte(CH_DOLLAR);
        endcase
      end else begin
        add_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  task automatic put_command(input int unsigned nargs);
    int unsigned len;
    put_header(CH_STAR, 64'(nargs), rand_zeros());
    repeat (nargs) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      put_header(CH_DOLLAR, 64'(len), rand_zeros());
      put_payload(len);
      put_crlf();
    end
  endtask

  // Leaves the parser right where a count or a length number starts.
  task automatic put_number_lead(input logic for_length);
    if (for_length) begin
      put_header(CH_STAR, 64'd1, 0);
      add_byte(CH_DOLLAR);
    end else begin
      add_byte(CH_STAR);
    end
  endtask

  // Ends the run as failed when nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("resp_request_stream_parser_unit verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: random stalls, plus one long hold-off while bytes keep coming.
  initial begin : result_drain
    int unsigned hold;
    int unsigned rounds;
    logic        quiet;
    logic        long_hold_done;
    rounds         = 0;
    quiet          = 1'b0;
    long_hold_done = 1'b0;
    forever begin
      if (rounds % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      rounds++;
      if (!long_hold_done && bytes_sent >= 150) begin
        hold           = LONG_HOLD;
        long_hold_done = 1'b1;
      end else begin
        hold = pick_gap(quiet);
      end
      if (hold != 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Byte side: builds the request stream, feeds it, then waits for the last result.
  initial begin : byte_feed
    int unsigned gap;
    int unsigned directed_len;
    logic        quiet;
    logic [63:0] widest;
    int unsigned len;
    tail_kind_t  tail;
    rst_n        <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.byte_in <= 8'h00;
    bytes_sent    = 0;

    // Directed: a zero-length argument, a leading zero, and the byte extremes as payload.
    put_header(CH_STAR, 64'd1, 0);
    put_header(CH_DOLLAR, 64'd0, 0);
    put_crlf();
    put_header(CH_STAR, 64'd2, 0);
    put_header(CH_DOLLAR, 64'd1, 1);
    add_byte(8'h00);
    put_crlf();
    put_header(CH_DOLLAR, 64'd1, 0);
    add_byte(8'hFF);
    put_crlf();
    directed_len = req_bytes.size();

    // Random well-formed commands.
    while (req_bytes.size() < directed_len + RANDOM_BYTES) begin
      put_command(($urandom_range(0, 7) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4));
    end

    // The stream ends with one framing error, or with the widest headers, then noise.
    widest                   = '0;
    widest[COUNT_BITS-1:0]   = '1;
    tail = tail_kind_t'($urandom_range(0, 7));
    case (tail)
      TAIL_PREFIX_STAR: add_byte(pick_other(CH_STAR));
      TAIL_PREFIX_DOLLAR: begin
        put_header(CH_STAR, 64'($urandom_range(1, 3)), 0);
        add_byte(pick_other(CH_DOLLAR));
      end
      TAIL_EMPTY_NUMBER: begin
        put_number_lead(1'($urandom_range(0, 1)));
        add_byte(pick_non_digit(1'b1));
      end
      TAIL_WIDE_NUMBER: begin
        put_number_lead(1'($urandom_range(0, 1)));
        put_digits(widest, $urandom_range(0, 2));
        add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      end
      TAIL_NUMBER_END: begin
        put_number_lead(1'($urandom_range(0, 1)));
        put_digits(64'($urandom_range(1, 9)), 0);
        if ($urandom_range(0, 1) == 0) begin
          add_byte(pick_non_digit(1'b0));
        end else begin
          add_byte(CH_CR);
          add_byte(pick_other(CH_LF));
        end
      end
      TAIL_PAYLOAD_END: begin
        len = $urandom_range(0, 3);
        put_header(CH_STAR, 64'd1, 0);
        put_header(CH_DOLLAR, 64'(len), 0);
        put_payload(len);
        if ($urandom_range(0, 1) == 0) begin
          add_byte(pick_other(CH_CR));
        end else begin
          add_byte(CH_CR);
          add_byte(pick_other(CH_LF));
        end
      end
      TAIL_ZERO_COUNT: put_header(CH_STAR, 64'd0, $urandom_range(0, 2));
      TAIL_MAX_HEADERS: begin
        put_header(CH_STAR, widest, 0);
        put_header(CH_DOLLAR, widest, 0);
      end
    endcase
    put_payload(6);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // One byte per transfer, with random gaps in front of some of them.
    quiet = 1'b0;
    foreach (req_bytes[i]) begin
      if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
      gap = pick_gap(quiet);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_ch.valid   <= 1'b1;
      in_ch.byte_in <= req_bytes[i];
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      bytes_sent++;
    end
    in_ch.valid <= 1'b0;

    // Drain the outstanding results, then keep watching for stray ones before the verdict.
    do @(posedge clk); while (pending != 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("resp_request_stream_parser_unit verification clean");
    end else begin
      $display("resp_request_stream_parser_unit verification failed");
    end
    $finish;
  end

endmodule
